/* rtl/mi4_pkg.sv */
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared widths, constants and types of the 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
package mi4_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_COLS   = 4;
   localparam int ROW_W      = NUM_COLS * DATA_WIDTH;
   localparam int MUL_W      = DATA_WIDTH + 1;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int COF_W      = 3 * DATA_WIDTH + 2;
   localparam int DET_W      = 4 * DATA_WIDTH + 4;
   localparam int QUO_W      = DATA_WIDTH + 1;
   localparam int REM_W      = DET_W + 1;
   localparam int NUM_SHIFT  = 2 * FRAC_BITS;
   localparam int DET_SHIFT  = 3 * FRAC_BITS;
   localparam int THR_W      = 31;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(((3 << FRAC_BITS) + 5) / 10);
   localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic       start_cof;
      logic       det_en;
      logic [1:0] col;
      logic       start_div;
   } lane_ctrl_type;

endpackage

/* rtl/matrix4_inverse_determinant.sv */
// Rows 0 to 2 are only stored. Row 3 starts the cofactor passes, and the
// inverse rows come out in order, paced by each lane's shared multiplier
// and its one-bit-per-cycle divider; a singular result is sent once the
// determinant is known. Reset clears control and sets the threshold to 0.3;
// stored rows are undefined until written.
// ----------------------------------------------------------------------------
// matrix4_inverse_determinant
// 4x4 fixed-point matrix inverse by adjugate, four cofactor lanes.
// ----------------------------------------------------------------------------
module matrix4_inverse_determinant import mi4_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ROW_W-1:0]                 req_tdata,  // in_col0..in_col3
   input  logic [1:0]                       req_tuser,  // row_index
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ROW_W+DATA_WIDTH-1:0]      rsp_tdata,  // inv_col0..inv_col3, det_value
   output logic [2:0]                       rsp_tuser,  // out_row, singular
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [THR_W-1:0]                 csr_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_COF   = 5'b00010,
      S_MERGE = 5'b00100,
      S_DIV   = 5'b01000,
      S_SEND  = 5'b10000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [1:0]            ci_ff, ci_in;
   lane_ctrl_type         ctrl_ff, ctrl_in;
   logic                  mstart_ff, mstart_in;
   logic [THR_W-1:0]      thresh_ff, thresh_in;
   logic [DATA_WIDTH-1:0] pend_ff [NUM_COLS];
   logic [DATA_WIDTH-1:0] pend_in [NUM_COLS];
   logic                  rvalid_ff, rvalid_in;
   logic [1:0]            orow_ff, orow_in;
   logic [ROW_W-1:0]      oinv_ff, oinv_in;
   logic [DATA_WIDTH-1:0] odet_ff, odet_in;
   logic                  osing_ff, osing_in;
   logic                  olast_ff, olast_in;

   logic                  accept, rsp_load;
   logic [NUM_COLS-1:0]   cof_done, div_done;
   logic [DET_W-1:0]      det_terms [NUM_COLS];
   logic [DATA_WIDTH-1:0] inv_elems [NUM_COLS];
   logic                  m_done, m_neg, m_sing;
   logic [DET_W-1:0]      m_mag;
   logic [DATA_WIDTH-1:0] m_detq;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign thresh_in = csr_valid ? csr_data : thresh_ff;

   for (genvar g = 0; g < NUM_COLS; g++) begin : g_lane
      mi4_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_id  (2'(g)),
         .wr_en    (accept),
         .wr_addr  (req_tuser),
         .wr_data  (req_tdata),
         .ctrl     (ctrl_ff),
         .det_mag  (m_mag),
         .det_neg  (m_neg),
         .cof_done (cof_done[g]),
         .div_done (div_done[g]),
         .det_term (det_terms[g]),
         .inv_elem (inv_elems[g])
      );
   end

   mi4_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .start     (mstart_ff),
      .det_terms (det_terms),
      .thresh    (thresh_ff),
      .done      (m_done),
      .det_mag   (m_mag),
      .det_neg   (m_neg),
      .det_q     (m_detq),
      .singular  (m_sing)
   );

   always_comb begin
      state_in  = state_ff;
      ci_in     = ci_ff;
      ctrl_in   = '0;
      mstart_in = 1'b0;
      pend_in   = pend_ff;
      rsp_load  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == 2'd3)) begin
               ctrl_in.start_cof = 1'b1;
               ctrl_in.det_en    = 1'b1;
               ctrl_in.col       = 2'd0;
               ci_in             = 2'd0;
               state_in          = S_COF;
            end
         end
         S_COF: begin
            if (&cof_done) begin
               if (ci_ff == 2'd0) begin
                  mstart_in = 1'b1;
                  state_in  = S_MERGE;
               end else begin
                  ctrl_in.start_div = 1'b1;
                  state_in          = S_DIV;
               end
            end
         end
         S_MERGE: begin
            if (m_done) begin
               if (m_sing) begin
                  state_in = S_SEND;
               end else begin
                  ctrl_in.start_div = 1'b1;
                  state_in          = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (&div_done) begin
               pend_in  = inv_elems;
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (!rvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               if (m_sing || (ci_ff == 2'd3)) begin
                  state_in = S_IDLE;
               end else begin
                  ci_in             = ci_ff + 2'd1;
                  ctrl_in.start_cof = 1'b1;
                  ctrl_in.col       = ci_ff + 2'd1;
                  state_in          = S_COF;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign orow_in  = m_sing ? 2'd0 : ci_ff;
   assign oinv_in  = m_sing ? '0 : {pend_ff[3], pend_ff[2], pend_ff[1], pend_ff[0]};
   assign odet_in  = m_detq;
   assign osing_in = m_sing;
   assign olast_in = m_sing || (ci_ff == 2'd3);
   assign rvalid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ctrl_ff   <= '0;
         mstart_ff <= 1'b0;
         thresh_ff <= THR_RESET;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ctrl_ff   <= ctrl_in;
         mstart_ff <= mstart_in;
         thresh_ff <= thresh_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff   <= ci_in;
      pend_ff <= pend_in;
      if (rsp_load) begin
         orow_ff  <= orow_in;
         oinv_ff  <= oinv_in;
         odet_ff  <= odet_in;
         osing_ff <= osing_in;
         olast_ff <= olast_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {odet_ff, oinv_ff};
   assign rsp_tuser  = {osing_ff, orow_ff};
   assign rsp_tlast  = olast_ff;

   // The lanes run in lockstep, so they finish together.
   assert property (@(posedge clock) disable iff (reset)
      (cof_done == '0) || (cof_done == '1))
      else $error("cofactor lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      (div_done == '0) || (div_done == '1))
      else $error("divider lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rvalid_ff || rsp_tready))
      else $error("result word overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && osing_ff) |-> olast_ff)
      else $error("singular result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      m_done |-> (state_ff == S_MERGE))
      else $error("determinant finished outside merge");

endmodule

/* rtl/mi4_ram.sv */
// ----------------------------------------------------------------------------
// mi4_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mi4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/mi4_lane.sv */
// ----------------------------------------------------------------------------
// mi4_lane
// One lane: forms a 3x3 cofactor with a shared multiplier, optionally its
// determinant term, and divides the cofactor by the determinant.
// ----------------------------------------------------------------------------
module mi4_lane import mi4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            lane_id,
   input  logic                  wr_en,
   input  logic [1:0]            wr_addr,
   input  logic [ROW_W-1:0]      wr_data,
   input  lane_ctrl_type         ctrl,
   input  logic [DET_W-1:0]      det_mag,
   input  logic                  det_neg,
   output logic                  cof_done,
   output logic                  div_done,
   output logic [DET_W-1:0]      det_term,
   output logic [DATA_WIDTH-1:0] inv_elem
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   typedef enum logic [4:0] {
      L_IDLE = 5'b00001,
      L_COF  = 5'b00010,
      L_DET  = 5'b00100,
      L_DIV  = 5'b01000,
      L_DEND = 5'b10000
   } lane_state_type;

   // n-th member of {0,1,2,3} without x
   function automatic logic [1:0] excl(input logic [1:0] x, input logic [1:0] n);
      excl = (n < x) ? n : n + 2'd1;
   endfunction

   function automatic logic [1:0] next3(input logic [1:0] k);
      case (k)
         2'd0:    next3 = 2'd1;
         2'd1:    next3 = 2'd2;
         default: next3 = 2'd0;
      endcase
   endfunction

   function automatic logic [MUL_W-1:0] sx(input logic [DATA_WIDTH-1:0] v);
      sx = {v[DATA_WIDTH-1], v};
   endfunction

   function automatic logic [MUL_W-1:0] zx(input logic [DATA_WIDTH-1:0] v);
      zx = {1'b0, v};
   endfunction

   lane_state_type state_ff, state_in;
   logic [1:0]              ph_ff, ph_in;
   logic [2:0]              tri_ff, tri_in;
   logic [2:0]              dstep_ff, dstep_in;
   logic [1:0]              col_ff, col_in;
   logic                    det_en_ff, det_en_in;
   logic [2*DATA_WIDTH-1:0] temp_ff, temp_in;
   logic [DATA_WIDTH-1:0]   a_ff, a_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    add_v_ff, add_v_in;
   logic [1:0]              add_sh_ff, add_sh_in;
   logic                    add_neg_ff, add_neg_in;
   logic                    add_det_ff, add_det_in;
   logic [COF_W-1:0]        cof_ff, cof_in;
   logic [DET_W-1:0]        det_ff, det_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        low_ff, low_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;
   logic                    qneg_ff, qneg_in;

   logic [1:0]              rd_addr0, rd_addr1;
   logic [ROW_W-1:0]        rd_data0, rd_data1;
   logic [1:0]              rs0, rs1, rs2, kk, col_a, col_p, col_q, col_b, col_c, col_sel;
   logic                    pol, neg_t;
   logic [DATA_WIDTH-1:0]   elem_a, elem_b, elem_c;
   logic [MUL_W-1:0]        mul_x, mul_y;
   logic signed [PROD_W-1:0] prod;
   logic [DET_W-1:0]        term_base, term;
   logic [COF_W-1:0]        cof_mag;
   logic [COF_W+NUM_SHIFT-1:0] num_mag;
   logic [REM_W-1:0]        div_d, r2;
   logic                    ge;

   mi4_ram #(.WIDTH(ROW_W), .DEPTH(NUM_COLS)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr0),
      .rd_data_a (rd_data0),
      .rd_addr_b (rd_addr1),
      .rd_data_b (rd_data1)
   );

   assign rs0   = excl(lane_id, 2'd0);
   assign rs1   = excl(lane_id, 2'd1);
   assign rs2   = excl(lane_id, 2'd2);
   assign kk    = tri_ff[2:1];
   assign pol   = tri_ff[0];
   assign col_a = excl(col_ff, kk);
   assign col_p = excl(col_ff, next3(kk));
   assign col_q = excl(col_ff, next3(next3(kk)));
   assign col_b = pol ? col_q : col_p;
   assign col_c = pol ? col_p : col_q;
   assign col_sel = (state_ff == L_DET) ? col_ff : col_a;
   // Second product of each pair is subtracted; odd cofactor positions flip it.
   assign neg_t = pol ^ col_ff[0] ^ lane_id[0];

   assign elem_a = rd_data0[col_sel*DATA_WIDTH +: DATA_WIDTH];
   assign elem_b = rd_data0[col_b*DATA_WIDTH +: DATA_WIDTH];
   assign elem_c = rd_data1[col_c*DATA_WIDTH +: DATA_WIDTH];

   assign prod = $signed(mul_x) * $signed(mul_y);

   assign term_base = {{(DET_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   always_comb begin
      case (add_sh_ff)
         2'd0:    term = term_base;
         2'd1:    term = term_base << DATA_WIDTH;
         2'd2:    term = term_base << (2 * DATA_WIDTH);
         default: term = term_base << (3 * DATA_WIDTH);
      endcase
   end

   assign cof_mag = cof_ff[COF_W-1] ? (COF_W'(0) - cof_ff) : cof_ff;
   assign num_mag = {cof_mag, {NUM_SHIFT{1'b0}}};
   assign div_d   = REM_W'(det_mag);
   assign r2      = {rem_ff[REM_W-2:0], low_ff[QUO_W-1]};
   assign ge      = (r2 >= div_d);

   always_comb begin
      state_in   = state_ff;
      ph_in      = ph_ff;
      tri_in     = tri_ff;
      dstep_in   = dstep_ff;
      col_in     = col_ff;
      det_en_in  = det_en_ff;
      temp_in    = temp_ff;
      a_in       = a_ff;
      prod_in    = prod;
      add_v_in   = 1'b0;
      add_sh_in  = 2'd0;
      add_neg_in = 1'b0;
      add_det_in = 1'b0;
      cof_in     = cof_ff;
      det_in     = det_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      qneg_in    = qneg_ff;
      rd_addr0   = rs1;
      rd_addr1   = rs2;
      mul_x      = '0;
      mul_y      = '0;
      cof_done   = 1'b0;
      div_done   = 1'b0;

      // Products are registered and added in the cycle after the multiply.
      if (add_v_ff) begin
         if (add_det_ff) begin
            det_in = det_ff + term;
         end else if (add_neg_ff) begin
            cof_in = cof_ff - term[COF_W-1:0];
         end else begin
            cof_in = cof_ff + term[COF_W-1:0];
         end
      end

      case (state_ff)
         L_IDLE: begin
            if (ctrl.start_cof) begin
               state_in  = L_COF;
               ph_in     = 2'd0;
               tri_in    = 3'd0;
               col_in    = ctrl.col;
               det_en_in = ctrl.det_en;
               cof_in    = '0;
               // The determinant term stays valid through the later column passes.
               if (ctrl.det_en) begin
                  det_in = '0;
               end
            end else if (ctrl.start_div) begin
               state_in = L_DIV;
               cnt_in   = '0;
               qneg_in  = cof_ff[COF_W-1] ^ det_neg;
               rem_in   = REM_W'(num_mag >> QUO_W);
               low_in   = num_mag[QUO_W-1:0];
            end
         end
         L_COF: begin
            case (ph_ff)
               2'd0: begin
                  rd_addr0 = rs1;
                  rd_addr1 = rs2;
                  ph_in    = 2'd1;
               end
               2'd1: begin
                  mul_x    = sx(elem_b);
                  mul_y    = sx(elem_c);
                  temp_in  = prod[2*DATA_WIDTH-1:0];
                  rd_addr0 = rs0;
                  ph_in    = 2'd2;
               end
               2'd2: begin
                  mul_x      = sx(elem_a);
                  mul_y      = zx(temp_ff[DATA_WIDTH-1:0]);
                  a_in       = elem_a;
                  add_v_in   = 1'b1;
                  add_sh_in  = 2'd0;
                  add_neg_in = neg_t;
                  ph_in      = 2'd3;
               end
               default: begin
                  mul_x      = sx(a_ff);
                  mul_y      = sx(temp_ff[2*DATA_WIDTH-1:DATA_WIDTH]);
                  add_v_in   = 1'b1;
                  add_sh_in  = 2'd1;
                  add_neg_in = neg_t;
                  ph_in      = 2'd0;
                  if (tri_ff == 3'd5) begin
                     state_in = L_DET;
                     dstep_in = 3'd0;
                  end else begin
                     tri_in = tri_ff + 3'd1;
                  end
               end
            endcase
         end
         L_DET: begin
            case (dstep_ff)
               3'd0: begin
                  rd_addr0 = lane_id;
                  if (det_en_ff) begin
                     dstep_in = 3'd1;
                  end else begin
                     cof_done = 1'b1;
                     state_in = L_IDLE;
                  end
               end
               3'd1: begin
                  mul_x      = sx(elem_a);
                  mul_y      = zx(cof_ff[DATA_WIDTH-1:0]);
                  a_in       = elem_a;
                  add_v_in   = 1'b1;
                  add_det_in = 1'b1;
                  add_sh_in  = 2'd0;
                  dstep_in   = 3'd2;
               end
               3'd2: begin
                  mul_x      = sx(a_ff);
                  mul_y      = zx(cof_ff[2*DATA_WIDTH-1:DATA_WIDTH]);
                  add_v_in   = 1'b1;
                  add_det_in = 1'b1;
                  add_sh_in  = 2'd1;
                  dstep_in   = 3'd3;
               end
               3'd3: begin
                  mul_x      = sx(a_ff);
                  mul_y      = zx(cof_ff[3*DATA_WIDTH-1:2*DATA_WIDTH]);
                  add_v_in   = 1'b1;
                  add_det_in = 1'b1;
                  add_sh_in  = 2'd2;
                  dstep_in   = 3'd4;
               end
               3'd4: begin
                  mul_x      = sx(a_ff);
                  mul_y      = {{(MUL_W-(COF_W-3*DATA_WIDTH)){cof_ff[COF_W-1]}},
                                cof_ff[COF_W-1:3*DATA_WIDTH]};
                  add_v_in   = 1'b1;
                  add_det_in = 1'b1;
                  add_sh_in  = 2'd3;
                  dstep_in   = 3'd5;
               end
               default: begin
                  cof_done = 1'b1;
                  state_in = L_IDLE;
               end
            endcase
         end
         L_DIV: begin
            if (cnt_ff == '0) begin
               // A quotient of 2^33 or more saturates whatever its low bits are.
               ovf_in = (rem_ff >= div_d);
               cnt_in = CNT_W'(1);
            end else begin
               rem_in = ge ? (r2 - div_d) : r2;
               low_in = {low_ff[QUO_W-2:0], ge};
               if (cnt_ff == CNT_W'(QUO_W)) begin
                  state_in = L_DEND;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         L_DEND: begin
            div_done = 1'b1;
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_comb begin
      if (!qneg_ff) begin
         inv_elem = (ovf_ff || (low_ff > {1'b0, SAT_MAX})) ? SAT_MAX
                                                         : low_ff[DATA_WIDTH-1:0];
      end else begin
         inv_elem = (ovf_ff || (low_ff > {1'b0, SAT_MIN})) ? SAT_MIN
                    : (DATA_WIDTH'(0) - low_ff[DATA_WIDTH-1:0]);
      end
   end

   assign det_term = det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         add_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         add_v_ff <= add_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff      <= ph_in;
      tri_ff     <= tri_in;
      dstep_ff   <= dstep_in;
      col_ff     <= col_in;
      det_en_ff  <= det_en_in;
      temp_ff    <= temp_in;
      a_ff       <= a_in;
      prod_ff    <= prod_in;
      add_sh_ff  <= add_sh_in;
      add_neg_ff <= add_neg_in;
      add_det_ff <= add_det_in;
      cof_ff     <= cof_in;
      det_ff     <= det_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      cnt_ff     <= cnt_in;
      ovf_ff     <= ovf_in;
      qneg_ff    <= qneg_in;
   end

endmodule

/* rtl/mi4_merge.sv */
// ----------------------------------------------------------------------------
// mi4_merge
// Sums the four lane determinant terms and derives magnitude, the
// truncated Q16.16 determinant and the singular decision.
// ----------------------------------------------------------------------------
module mi4_merge import mi4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DET_W-1:0]      det_terms [NUM_COLS],
   input  logic [THR_W-1:0]      thresh,
   output logic                  done,
   output logic [DET_W-1:0]      det_mag,
   output logic                  det_neg,
   output logic [DATA_WIDTH-1:0] det_q,
   output logic                  singular
);

   logic [3:0]            v_ff, v_in;
   logic [DET_W-1:0]      sum01_ff, sum01_in;
   logic [DET_W-1:0]      sum23_ff, sum23_in;
   logic [DET_W-1:0]      det_ff, det_in;
   logic [DET_W-1:0]      mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH-1:0] detq_ff, detq_in;
   logic                  sing_ff, sing_in;
   logic [DET_W-1:0]      mag_sh;
   logic [DET_W-1:0]      thr_scaled;

   assign v_in     = {v_ff[2:0], start};
   assign sum01_in = det_terms[0] + det_terms[1];
   assign sum23_in = det_terms[2] + det_terms[3];
   assign det_in   = sum01_ff + sum23_ff;
   assign neg_in   = det_ff[DET_W-1];
   assign mag_in   = det_ff[DET_W-1] ? (DET_W'(0) - det_ff) : det_ff;

   assign mag_sh     = mag_ff >> DET_SHIFT;
   assign thr_scaled = DET_W'(thresh) << DET_SHIFT;
   // A zero determinant is singular even with a zero threshold.
   assign sing_in    = (mag_ff == '0) || (mag_ff < thr_scaled);

   always_comb begin
      if (!neg_ff) begin
         detq_in = (mag_sh > DET_W'(SAT_MAX)) ? SAT_MAX : mag_sh[DATA_WIDTH-1:0];
      end else begin
         detq_in = (mag_sh > DET_W'(SAT_MIN)) ? SAT_MIN
                   : (DATA_WIDTH'(0) - mag_sh[DATA_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      sum01_ff <= sum01_in;
      sum23_ff <= sum23_in;
      det_ff   <= det_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      if (v_ff[2]) begin
         detq_ff <= detq_in;
         sing_ff <= sing_in;
      end
   end

   assign done     = v_ff[3];
   assign det_mag  = mag_ff;
   assign det_neg  = neg_ff;
   assign det_q    = detq_ff;
   assign singular = sing_ff;

endmodule
